// ===== src/rwg_pkg.sv =====
package rwg_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int FREQ_W    = 16;
  localparam int FREQ_FRAC = 8;
  localparam int AMP_W     = 32;
  localparam int OUT_W     = 32;

  // Default sizing for the top level
  localparam int DEF_EXP_TABLE_DEPTH = 256;
  localparam int DEF_FRAC_BITS       = 16;

  // Q32 constants
  localparam int          PI_W      = 34;
  localparam logic [33:0] PI_Q32    = 34'd13493037705;
  localparam int          LOG2E_W   = 33;
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam int          TAYLOR_TERMS = 24;

  // exp(-x) value width, Q32 with one integer bit
  localparam int EXP_W = 33;

  // Pipeline depth, stage 1 takes the input, the last stage is the output register
  localparam int NUM_STAGES = 13;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WINDOW_START     = 3'd0;
  localparam cfg_idx_t REG_WINDOW_FINISH    = 3'd1;
  localparam cfg_idx_t REG_CENTRE_FREQUENCY = 3'd2;
  localparam cfg_idx_t REG_PEAK_DELAY       = 3'd3;
  localparam cfg_idx_t REG_AMPLITUDE        = 3'd4;

  // Stage enables for the exponential unit
  typedef struct packed {
    logic ld_y;
    logic ld_idx;
    logic ld_tab;
    logic ld_mul;
    logic ld_e;
  } exp_adv_t;

endpackage

// ===== src/rwg_exp.sv =====
module rwg_exp #(
  parameter int FRAC_BITS       = rwg_pkg::DEF_FRAC_BITS,
  parameter int EXP_TABLE_DEPTH = rwg_pkg::DEF_EXP_TABLE_DEPTH
) (
  input  logic                     clk,
  input  rwg_pkg::exp_adv_t        adv,
  input  logic [FRAC_BITS+4:0]     x,
  output logic [rwg_pkg::EXP_W-1:0] e
);
  import rwg_pkg::*;

  localparam int X_W   = FRAC_BITS + 5;
  localparam int YP_W  = X_W + LOG2E_W;
  localparam int Y_W   = YP_W - 32;
  localparam int K_W   = Y_W - FRAC_BITS;
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SC_W  = FRAC_BITS + IDX_W;
  localparam int IP_W  = EXP_W + FRAC_BITS;

  typedef logic [EXP_W-1:0] tab_t [EXP_TABLE_DEPTH+1];

  // 2^-(i/DEPTH) in Q32 by Taylor series of exp(-u), evaluated at elaboration
  function automatic tab_t build_tab();
    tab_t               tab;
    logic [63:0]        u;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      u    = (64'(i) * LN2_Q32) / EXP_TABLE_DEPTH;
      term = ONE_Q32;
      sum  = signed'(ONE_Q32);
      for (int Nt = 1; Nt <= TAYLOR_TERMS; Nt++) begin
        term = ((term * u) >> 32) / 64'(Nt);
        if (Nt % 2 == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      tab[i] = EXP_W'(sum);
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  logic [YP_W-1:0]      yp_r;
  logic [Y_W-1:0]       y;
  logic [SC_W-1:0]      scaled;
  logic [IDX_W-1:0]     idx_raw;
  logic [IDX_W-1:0]     idx_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [FRAC_BITS-1:0] rem_r, rem8_r;
  logic [K_W-1:0]       k_r, k8_r, k9_r;
  logic [EXP_W-1:0]     lo_r, hi_r, lo9_r;
  logic [IP_W-1:0]      ip_r;
  logic [EXP_W-1:0]     e_lin;
  logic [EXP_W-1:0]     e_r;

  // y = x * log2(e): integer part is the shift, fraction indexes the table
  assign y       = yp_r[YP_W-1:32];
  assign scaled  = SC_W'(y[FRAC_BITS-1:0]) * SC_W'(EXP_TABLE_DEPTH);
  assign idx_raw = scaled[SC_W-1:FRAC_BITS];
  assign idx_nxt = (idx_raw >= IDX_W'(EXP_TABLE_DEPTH)) ?
                   IDX_W'(EXP_TABLE_DEPTH - 1) : idx_raw;

  // Linear interpolation between neighboring entries
  assign e_lin = lo9_r - ip_r[IP_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv.ld_y) begin
      yp_r <= YP_W'(x) * YP_W'(LOG2E_Q32);
    end
    if (adv.ld_idx) begin
      idx_r <= idx_nxt;
      rem_r <= scaled[FRAC_BITS-1:0];
      k_r   <= y[Y_W-1:FRAC_BITS];
    end
    if (adv.ld_tab) begin
      lo_r   <= EXP_TAB[idx_r];
      hi_r   <= EXP_TAB[idx_r + IDX_W'(1)];
      rem8_r <= rem_r;
      k8_r   <= k_r;
    end
    if (adv.ld_mul) begin
      ip_r  <= IP_W'(lo_r - hi_r) * IP_W'(rem8_r);
      lo9_r <= lo_r;
      k9_r  <= k8_r;
    end
    if (adv.ld_e) begin
      e_r <= e_lin >> k9_r;
    end
  end

  assign e = e_r;

endmodule

// ===== src/ricker_wavelet_generator.sv =====
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_valid/in_stall  | in_sample_time (u32, Q.F seconds)
// out_    | out | out_valid/out_stall| out_force_value (s32, Q.F), out_in_window
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index (3 b), cfg_data (32 b)
//
// One sample per clock while the output is not stalled; the pipeline stages run from
// the window compare through the multiplier stages and the exp(-x) table.
// Stages advance independently, so bubbles close up behind a stalled output.
// in_stall rises only when every stage holds a sample and out_stall is high.
// Reset clears the stage valid bits and loads the register reset values;
// configuration writes are always taken (cfg_ready is tied high).
module ricker_wavelet_generator #(
  parameter int EXP_TABLE_DEPTH = rwg_pkg::DEF_EXP_TABLE_DEPTH,
  parameter int FRAC_BITS       = rwg_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rwg_pkg::TIME_W-1:0]    in_sample_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rwg_pkg::OUT_W-1:0] out_force_value,
  output logic                          out_in_window,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  rwg_pkg::cfg_idx_t             cfg_index,
  input  logic [rwg_pkg::AMP_W-1:0]     cfg_data
);
  import rwg_pkg::*;

  localparam int P_W   = TIME_W + FREQ_W;
  localparam int PQ_W  = P_W - FREQ_FRAC;
  localparam int WP_W  = FRAC_BITS + 1 + PI_W;
  localparam int W_W   = WP_W - 32;
  localparam int SQ_W  = 2 * W_W;
  localparam int X_W   = SQ_W - FRAC_BITS;
  localparam int G_W   = X_W;
  localparam int M1_W  = AMP_W + G_W;
  localparam int M1H_W = M1_W - 32;
  localparam int MH_W  = M1H_W + EXP_W;
  localparam int ML_W  = 32 + EXP_W;
  localparam int SUM_W = MH_W + 2;
  localparam int MAG_W = SUM_W - FRAC_BITS;

  localparam logic [AMP_W-1:0] AMP_ONE  = AMP_W'(64'd1 << FRAC_BITS);
  localparam logic [G_W-1:0]   G_ONE    = G_W'(64'd1 << FRAC_BITS);
  localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(64'h8000_0000);
  localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'(64'h7FFF_FFFF);
  localparam logic [NUM_STAGES:1] ALL_STAGES = '1;

  typedef struct packed {
    logic inw;
    logic kill;
    logic neg;
  } tag_t;

  // Configuration registers
  logic [TIME_W-1:0] ws_r, wf_r, pd_r;
  logic [FREQ_W-1:0] freq_r;
  logic [AMP_W-1:0]  amp_r;

  // Pipeline control
  logic [NUM_STAGES:1] valid_r;
  logic [NUM_STAGES:1] adv;
  logic                in_acc;
  exp_adv_t            exp_adv;

  // Datapath
  logic                 s1_inw_r;
  logic [TIME_W-1:0]    s1_diff_r;
  logic [TIME_W:0]      d;
  logic [TIME_W:0]      d_neg;
  logic                 s2_inw_r;
  logic [TIME_W-1:0]    s2_ad_r;
  logic                 s3_inw_r;
  logic [P_W-1:0]       s3_p_r;
  logic [PQ_W-1:0]      pq;
  logic                 s4_inw_r, s4_far_r;
  logic [WP_W-1:0]      s4_wp_r;
  logic [W_W-1:0]       w;
  logic                 s5_inw_r, s5_far_r;
  logic [SQ_W-1:0]      s5_sq_r;
  logic [X_W-1:0]       x;
  logic [G_W-1:0]       two_x;
  logic                 gneg;
  logic [G_W-1:0]       s6_gmag_r;
  logic                 s6_gneg_r;
  logic                 s6_inw_r, s6_kill_r;
  logic [AMP_W-1:0]     amag;
  tag_t                 tag_r [7:12];
  logic [M1_W-1:0]      m1_r [7:10];
  logic [EXP_W-1:0]     e;
  logic [ML_W-1:0]      ml_full;
  logic [MH_W-1:0]      s11_mh_r;
  logic [EXP_W-1:0]     s11_ml_r;
  logic [SUM_W-1:0]     s12_sum_r;
  logic [MAG_W-1:0]     mag;
  logic [OUT_W-1:0]     force_nxt;
  logic [OUT_W-1:0]     force_r;
  logic                 inw_out_r;

  // Configuration write transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      wf_r   <= '0;
      freq_r <= '0;
      pd_r   <= '0;
      amp_r  <= AMP_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_START:     ws_r   <= cfg_data;
        REG_WINDOW_FINISH:    wf_r   <= cfg_data;
        REG_CENTRE_FREQUENCY: freq_r <= cfg_data[FREQ_W-1:0];
        REG_PEAK_DELAY:       pd_r   <= cfg_data;
        REG_AMPLITUDE:        amp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage moves when it is empty or nothing from it to the output is blocked;
  // stages below i are masked to one so only stages i and up are tested
  always_comb begin
    for (int i = 1; i <= NUM_STAGES; i++) begin
      adv[i] = !out_stall || !(&(valid_r | ~(ALL_STAGES << (i - 1))));
    end
  end

  assign in_stall = !adv[1];
  assign in_acc   = in_valid && adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[1]) begin
        valid_r[1] <= in_acc;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (adv[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  // Stage 2: signed offset from the peak and its magnitude
  assign d     = {1'b0, s1_diff_r} - {1'b0, pd_r};
  assign d_neg = -d;

  // Stage 4: f*|d| in Q.F and the range check
  assign pq = s3_p_r[P_W-1:FREQ_FRAC];

  // Stage 5: w = pi*f*|d|
  assign w = s4_wp_r[WP_W-1:32];

  // Stage 6: x = w^2, reach check, |2x-1|
  assign x     = s5_sq_r[SQ_W-1:FRAC_BITS];
  assign two_x = {x[X_W-2:0], 1'b0};
  assign gneg  = two_x < G_ONE;

  // Stage 7: |amplitude|, the most negative value maps to 2^31
  assign amag = amp_r[AMP_W-1] ? (~amp_r + AMP_W'(1)) : amp_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_inw_r  <= (in_sample_time >= ws_r) && (in_sample_time <= wf_r);
      s1_diff_r <= in_sample_time - ws_r;
    end
    if (adv[2]) begin
      s2_inw_r <= s1_inw_r;
      s2_ad_r  <= d[TIME_W] ? d_neg[TIME_W-1:0] : d[TIME_W-1:0];
    end
    if (adv[3]) begin
      s3_inw_r <= s2_inw_r;
      s3_p_r   <= P_W'(freq_r) * P_W'(s2_ad_r);
    end
    if (adv[4]) begin
      s4_inw_r <= s3_inw_r;
      s4_far_r <= |pq[PQ_W-1:FRAC_BITS+1];
      s4_wp_r  <= WP_W'(pq[FRAC_BITS:0]) * WP_W'(PI_Q32);
    end
    if (adv[5]) begin
      s5_inw_r <= s4_inw_r;
      s5_far_r <= s4_far_r;
      s5_sq_r  <= SQ_W'(w) * SQ_W'(w);
    end
    if (adv[6]) begin
      s6_inw_r  <= s5_inw_r;
      s6_kill_r <= s5_far_r || x[X_W-1];
      s6_gneg_r <= gneg;
      s6_gmag_r <= gneg ? (G_ONE - two_x) : (two_x - G_ONE);
    end
    if (adv[7]) begin
      tag_r[7] <= '{inw: s6_inw_r, kill: s6_kill_r, neg: amp_r[AMP_W-1] ^ s6_gneg_r};
      m1_r[7]  <= M1_W'(amag) * M1_W'(s6_gmag_r);
    end
    for (int i = 8; i <= 12; i++) begin
      if (adv[i]) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
    for (int i = 8; i <= 10; i++) begin
      if (adv[i]) begin
        m1_r[i] <= m1_r[i-1];
      end
    end
    if (adv[11]) begin
      s11_mh_r <= MH_W'(m1_r[10][M1_W-1:32]) * MH_W'(e);
      s11_ml_r <= ml_full[ML_W-1:32];
    end
    if (adv[12]) begin
      s12_sum_r <= SUM_W'(s11_mh_r) + SUM_W'(s11_ml_r) + HALF_LSB;
    end
    if (adv[13]) begin
      force_r   <= force_nxt;
      inw_out_r <= tag_r[12].inw;
    end
  end

  // Stage 11 low partial product
  assign ml_full = ML_W'(m1_r[10][31:0]) * ML_W'(e);

  // exp(-x) over stages 6 to 10
  assign exp_adv = '{ld_y: adv[6], ld_idx: adv[7], ld_tab: adv[8],
                     ld_mul: adv[9], ld_e: adv[10]};

  rwg_exp #(
    .FRAC_BITS       (FRAC_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk (clk),
    .adv (exp_adv),
    .x   (x[X_W-2:0]),
    .e   (e)
  );

  // Stage 13: rescale, saturate, apply sign, blank outside the window or when killed
  assign mag = s12_sum_r[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (!tag_r[12].inw || tag_r[12].kill) begin
      force_nxt = '0;
    end else if (tag_r[12].neg) begin
      force_nxt = (mag > MAG_NEG_LIM) ? OUT_W'(64'h8000_0000) : -mag[OUT_W-1:0];
    end else begin
      force_nxt = (mag > MAG_POS_LIM) ? OUT_W'(64'h7FFF_FFFF) : mag[OUT_W-1:0];
    end
  end

  assign out_valid       = valid_r[NUM_STAGES];
  assign out_force_value = signed'(force_r);
  assign out_in_window   = inw_out_r;

  // Input backs up only when the whole pipe is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("input stalled with room in the pipeline");

  // An accepted transaction occupies stage 1 on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[1])
    else $error("accepted transaction lost at stage 1");

  // Samples outside the window give a zero force
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_force_value == '0)
    else $error("nonzero force outside the window");

endmodule
